// ===== src/telemetry_frame_builder_defines.svh =====
// ----------------------------------------------------------------------------
// Telemetry frame builder assertion macros
// Shared macros for the concurrent checks in the controller and datapath.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_BUILDER_DEFINES_SVH
`define TELEMETRY_FRAME_BUILDER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define TFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define TFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TFB_ASSERT_NOW(lbl, ante, cons, msg)
`define TFB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/tfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame builder package
// Payload types, frame constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tfb_pkg;

  // Frame kind codes carried in the operation field.
  localparam logic [1:0] OP_CUSTOM = 2'd0;
  localparam logic [1:0] OP_SENSOR = 2'd1;
  localparam logic [1:0] OP_ANGLE  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Header bytes and kind codes on the wire.
  localparam logic [7:0] FRAME_HEAD0 = 8'hAA;
  localparam logic [7:0] FRAME_HEAD1 = 8'hFF;
  localparam logic [7:0] CODE_CUSTOM = 8'hF1;
  localparam logic [7:0] CODE_SENSOR = 8'h01;
  localparam logic [7:0] CODE_ANGLE  = 8'h03;

  // Angle values are scaled by this factor and wrapped to 16 bits.
  localparam logic [15:0] ANGLE_SCALE = 16'd100;

  // Byte position within a frame; the longest frame has 19 bytes.
  localparam int unsigned FRAME_MAX = 19;
  localparam int unsigned IDX_W     = $clog2(FRAME_MAX);

  // Header is four bytes, checksum two; payload starts at this position.
  localparam logic [IDX_W-1:0] PAYLOAD_START = IDX_W'(4);
  localparam logic [IDX_W-1:0] FRAME_OVERHEAD = IDX_W'(6);

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic signed [15:0] value_c;
    logic signed [15:0] value_d;
    logic signed [15:0] value_e;
    logic signed [15:0] value_f;
    logic [7:0]         status_byte;
  } in_t;

  // Output transaction payload.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } out_t;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic ld;    // capture a new request and clear the checksums
    logic step;  // load the next frame byte into the output register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic last;  // the current byte position is the final checksum byte
  } sts_t;

  // Total frame length in bytes for each kind.
  function automatic logic [IDX_W-1:0] frame_len_f(input logic [1:0] op);
    logic [IDX_W-1:0] len;
    case (op)
      OP_CUSTOM: len = IDX_W'(18);
      OP_SENSOR: len = IDX_W'(19);
      OP_ANGLE:  len = IDX_W'(13);
      default:   len = IDX_W'(FRAME_MAX);
    endcase
    return len;
  endfunction

  // Kind code byte for each kind.
  function automatic logic [7:0] kind_code_f(input logic [1:0] op);
    logic [7:0] code;
    case (op)
      OP_CUSTOM: code = CODE_CUSTOM;
      OP_SENSOR: code = CODE_SENSOR;
      OP_ANGLE:  code = CODE_ANGLE;
      default:   code = CODE_CUSTOM;
    endcase
    return code;
  endfunction

endpackage

// ===== src/tfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame builder controller
// Sequences request capture and byte emission, and owns the output valid.
// ----------------------------------------------------------------------------
`include "telemetry_frame_builder_defines.svh"

module tfb_ctrl
  import tfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   accept;
  logic   step;

  // The output register can take a byte when it is empty or being drained.
  assign slot_free = !out_valid_r || out_ready;
  assign step      = (state_r == ST_EMIT) && slot_free;

  // A new request is taken when idle, or in the cycle the last byte moves out.
  assign in_ready = (state_r == ST_IDLE) || (step && sts.last);
  assign accept   = in_valid && in_ready;

  assign cmd.ld   = accept;
  assign cmd.step = step;

  assign out_valid = out_valid_r;

  // Next-state logic; an unused kind code is taken and dropped.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_op != OP_NONE)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (step && sts.last) begin
          state_nxt = (accept && (in_op != OP_NONE)) ? ST_EMIT : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid follows loads and drains of the output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A stepped byte is presented in the following cycle.
  `TFB_ASSERT_NEXT(a_step_gives_valid, step, out_valid_r, "stepped byte not presented")
  // A request with the unused kind code produces no frame.
  `TFB_ASSERT_NEXT(a_drop_unused, accept && (in_op == OP_NONE), state_r == ST_IDLE, "unused kind started a frame")
  // After the final byte, the controller is ready again unless a new frame began.
  `TFB_ASSERT_NEXT(a_last_frees, step && sts.last && !accept, in_ready, "not ready after frame end")

endmodule

// ===== src/tfb_dp.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame builder datapath
// Holds the request, selects each frame byte and keeps the running checksums.
// ----------------------------------------------------------------------------
`include "telemetry_frame_builder_defines.svh"

module tfb_dp
  import tfb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  cmd_t cmd,
  output sts_t sts,
  output out_t out_data
);

  in_t              req_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       acc_r, acc_nxt;
  out_t             out_r;

  logic [IDX_W-1:0] frame_len;
  logic [IDX_W-1:0] word_off;
  logic [2:0]       word_idx;
  logic [15:0]      word_raw;
  logic [31:0]      word_prod;
  logic [15:0]      word_val;
  logic [7:0]       byte_sel;
  logic             in_body;

  assign frame_len = frame_len_f(req_r.operation);
  assign sts.last  = (idx_r == frame_len - IDX_W'(1));
  assign out_data  = out_r;

  // Payload word chosen by byte position; two bytes per word.
  assign word_off = idx_r - PAYLOAD_START;
  assign word_idx = word_off[3:1];

  always_comb begin
    case (word_idx)
      3'd0:    word_raw = req_r.value_a;
      3'd1:    word_raw = req_r.value_b;
      3'd2:    word_raw = req_r.value_c;
      3'd3:    word_raw = req_r.value_d;
      3'd4:    word_raw = req_r.value_e;
      3'd5:    word_raw = req_r.value_f;
      default: word_raw = 16'd0;
    endcase
  end

  // Angle frames scale each value and keep the low 16 bits of the product.
  assign word_prod = {16'd0, word_raw} * {16'd0, ANGLE_SCALE};
  assign word_val  = (req_r.operation == OP_ANGLE) ? word_prod[15:0] : word_raw;

  // Byte selection by position within the frame.
  always_comb begin
    if (idx_r == IDX_W'(0)) begin
      byte_sel = FRAME_HEAD0;
    end else if (idx_r == IDX_W'(1)) begin
      byte_sel = FRAME_HEAD1;
    end else if (idx_r == IDX_W'(2)) begin
      byte_sel = kind_code_f(req_r.operation);
    end else if (idx_r == IDX_W'(3)) begin
      byte_sel = 8'(frame_len - FRAME_OVERHEAD);
    end else if (idx_r == frame_len - IDX_W'(1)) begin
      byte_sel = acc_r;
    end else if (idx_r == frame_len - IDX_W'(2)) begin
      byte_sel = sum_r;
    end else if ((req_r.operation != OP_CUSTOM) && (idx_r == frame_len - IDX_W'(3))) begin
      byte_sel = req_r.status_byte;
    end else begin
      byte_sel = word_off[0] ? word_val[15:8] : word_val[7:0];
    end
  end

  // Header, payload and status bytes feed the checksums; the checksum bytes do not.
  assign in_body = (idx_r < frame_len - IDX_W'(2));

  always_comb begin
    idx_nxt = idx_r;
    sum_nxt = sum_r;
    acc_nxt = acc_r;
    if (cmd.ld) begin
      idx_nxt = '0;
      sum_nxt = 8'd0;
      acc_nxt = 8'd0;
    end else if (cmd.step) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (in_body) begin
        sum_nxt = sum_r + byte_sel;
        acc_nxt = acc_r + sum_nxt;
      end
    end
  end

  // Position counter is control state and is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // Request, checksum and output registers.
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    acc_r <= acc_nxt;
    if (cmd.ld) begin
      req_r <= in_data;
    end
    if (cmd.step) begin
      out_r.frame_byte   <= byte_sel;
      out_r.end_of_frame <= sts.last;
    end
  end

  // A new request always restarts at the first header byte.
  `TFB_ASSERT_NEXT(a_ld_restart, cmd.ld, idx_r == '0, "position not cleared on load")
  // Stepping never runs past the end of the frame.
  `TFB_ASSERT_NOW(a_step_in_frame, cmd.step, idx_r < frame_len, "byte position beyond frame")
  // The frame end flag goes out together with the accumulated checksum byte.
  `TFB_ASSERT_NEXT(a_eof_is_acc, cmd.step && sts.last && !cmd.ld, out_r.frame_byte == $past(acc_r), "end of frame byte is not the second checksum")

endmodule

// ===== src/telemetry_frame_builder.sv =====
// An accepted request is registered; its first byte then loads into the output register.
// Throughput: one byte per cycle unless the output stalls; frames are 13, 18 or 19 bytes,
// and the next request is taken as the last byte of a frame is loaded.
// Output backpressure stalls the sequencer; a request with the unused kind code is dropped.
// Reset: rst_n is synchronous and active low and returns the block to idle with no output.
// ----------------------------------------------------------------------------
// Telemetry frame builder
// Turns each frame request into a byte stream with header, payload and checksums.
// ----------------------------------------------------------------------------
module telemetry_frame_builder
  import tfb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  // Controller: request handshake, byte sequencing and output valid.
  tfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: request storage, byte selection and checksums.
  tfb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
